>>> sv/blc_pkg.sv
// ----------------------------------------------------------------------------
// Bicolor LED blink controller package
// Transfer types, request and mode codes, and register reset values.
// ----------------------------------------------------------------------------
package blc_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned PHASE_W  = PERIOD_W + 1;
    localparam int unsigned LIFE_W   = 15;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [1:0] REQ_TICK        = 2'd0;
    localparam logic [1:0] REQ_SET_FOREVER = 2'd1;
    localparam logic [1:0] REQ_SET_TEMP    = 2'd2;

    localparam logic [2:0] MODE_OFF          = 3'd0;
    localparam logic [2:0] MODE_FLASH_GREEN  = 3'd1;
    localparam logic [2:0] MODE_FLASH_RED    = 3'd2;
    localparam logic [2:0] MODE_STEADY_GREEN = 3'd3;
    localparam logic [2:0] MODE_STEADY_RED   = 3'd4;
    localparam logic [2:0] MODE_ALTERNATE    = 3'd5;
    localparam logic [2:0] MODE_OFFLINE      = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_PERIOD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_PERIOD = 1'd1;

    localparam logic [PERIOD_W-1:0] ON_PERIOD_RESET  = 16'd500;
    localparam logic [PERIOD_W-1:0] OFF_PERIOD_RESET = 16'd500;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [2:0]        new_mode;
        logic [LIFE_W-1:0] lifetime_ms;
    } blc_req_t;

    typedef struct packed {
        logic green_on;
        logic red_on;
        logic drive_enable;
    } blc_rsp_t;

endpackage

>>> sv/blc_in_reg.sv
// ----------------------------------------------------------------------------
// Request input register
// Holds one accepted request until the core consumes it.
// ----------------------------------------------------------------------------
module blc_in_reg
    import blc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  blc_req_t load_data,
    input  logic     advance,
    output logic     valid,
    output blc_req_t data
);

    logic     valid_reg;
    logic     valid_next;
    blc_req_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> sv/blc_core.sv
// ----------------------------------------------------------------------------
// Blink controller core
// Mode, lifetime, phase and pin state, updated once per consumed request.
// ----------------------------------------------------------------------------
module blc_core
    import blc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [PERIOD_W-1:0]  cfg_wdata,
    input  logic                 fire,
    input  blc_req_t             item,
    output blc_rsp_t             result
);

    logic [PERIOD_W-1:0] on_period_reg;
    logic [PERIOD_W-1:0] off_period_reg;
    logic [2:0]          mode_reg;
    logic [2:0]          mode_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [LIFE_W-1:0]   life_reg;
    logic [LIFE_W-1:0]   life_next;
    logic                hold_reg;
    logic                hold_next;
    logic                green_reg;
    logic                green_next;
    logic                red_reg;
    logic                red_next;

    logic [PHASE_W-1:0]  period;
    logic [PHASE_W:0]    phase_inc;
    logic                stage;
    logic [2:0]          tick_mode;

    assign period = {1'b0, on_period_reg} + {1'b0, off_period_reg};
    assign stage  = (period != '0) && (phase_reg < {1'b0, on_period_reg});
    assign phase_inc = {1'b0, phase_reg} + {{PHASE_W{1'b0}}, 1'b1};

    always_comb
    begin
        tick_mode = mode_reg;
        if (!hold_reg && (life_reg == '0))
        begin
            tick_mode = MODE_OFF;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        life_next  = life_reg;
        hold_next  = hold_reg;
        green_next = green_reg;
        red_next   = red_reg;
        unique case (item.req_type)
            REQ_TICK:
            begin
                mode_next = tick_mode;
                if (!hold_reg)
                begin
                    if (life_reg != '0)
                    begin
                        life_next = life_reg - {{(LIFE_W-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        hold_next = 1'b1;
                    end
                end
                unique case (tick_mode)
                    MODE_FLASH_GREEN:
                    begin
                        green_next = stage;
                        red_next   = 1'b0;
                    end
                    MODE_FLASH_RED:
                    begin
                        green_next = 1'b0;
                        red_next   = stage;
                    end
                    MODE_STEADY_GREEN:
                    begin
                        green_next = 1'b1;
                        red_next   = 1'b0;
                    end
                    MODE_STEADY_RED:
                    begin
                        green_next = 1'b0;
                        red_next   = 1'b1;
                    end
                    MODE_ALTERNATE:
                    begin
                        green_next = stage;
                        red_next   = !stage;
                    end
                    MODE_OFFLINE:
                    begin
                        green_next = green_reg;
                        red_next   = red_reg;
                    end
                    default:
                    begin
                        green_next = 1'b0;
                        red_next   = 1'b0;
                    end
                endcase
                if ((period == '0) || (phase_inc >= {1'b0, period}))
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_inc[PHASE_W-1:0];
                end
            end
            REQ_SET_FOREVER:
            begin
                mode_next = item.new_mode;
                hold_next = 1'b1;
                life_next = '0;
            end
            REQ_SET_TEMP:
            begin
                mode_next = item.new_mode;
                hold_next = 1'b0;
                life_next = item.lifetime_ms;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_period_reg  <= ON_PERIOD_RESET;
            off_period_reg <= OFF_PERIOD_RESET;
            mode_reg       <= MODE_OFF;
            phase_reg      <= '0;
            life_reg       <= '0;
            hold_reg       <= 1'b1;
            green_reg      <= 1'b0;
            red_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_addr == CFG_ON_PERIOD))
            begin
                on_period_reg <= cfg_wdata;
            end
            if (cfg_wr_en && (cfg_addr == CFG_OFF_PERIOD))
            begin
                off_period_reg <= cfg_wdata;
            end
            if (fire)
            begin
                mode_reg  <= mode_next;
                phase_reg <= phase_next;
                life_reg  <= life_next;
                hold_reg  <= hold_next;
                green_reg <= green_next;
                red_reg   <= red_next;
            end
        end
    end

    assign result.green_on     = green_next;
    assign result.red_on       = red_next;
    assign result.drive_enable = (mode_next != MODE_OFFLINE);

    a_hold_clears_life: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> (life_reg == '0))
        else $error("lifetime left while holding forever");

    a_set_forever_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.req_type == REQ_SET_FOREVER)) |=> hold_reg)
        else $error("set forever did not set the hold");

    a_zero_period_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.req_type == REQ_TICK) && (period == '0)) |=> (phase_reg == '0))
        else $error("phase moved with a zero period");

    a_offline_keeps_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.req_type == REQ_TICK) && (tick_mode == MODE_OFFLINE))
        |=> ($stable(green_reg) && $stable(red_reg)))
        else $error("pins changed in offline mode");

endmodule

>>> sv/blc_out_reg.sv
// ----------------------------------------------------------------------------
// Response output register
// Holds one result until the response transfer completes.
// ----------------------------------------------------------------------------
module blc_out_reg
    import blc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  blc_rsp_t load_data,
    input  logic     take,
    output logic     can_load,
    output logic     valid,
    output blc_rsp_t data
);

    logic     valid_reg;
    logic     valid_next;
    blc_rsp_t data_reg;

    assign can_load = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> sv/bicolor_led_blink_controller.sv
// ----------------------------------------------------------------------------
// Bicolor LED blink controller
// Drives a red/green LED pair from millisecond ticks and mode commands.
//
//   Channel   Signals                        Payload
//   req       req_valid, req_ready, req      blc_req_t: type, mode, lifetime
//   rsp       rsp_valid, rsp_ready, rsp      blc_rsp_t: green, red, drive
//   cfg       cfg_wr_en, cfg_addr, cfg_wdata on and off period, 16 bits each
//
// One request is accepted per cycle while no stalled response holds the path;
// the path is request register, state update logic, response register.
// Reset clears both registers and sets the periods to 500 and the mode to off.
// A stalled response holds; one more request is accepted behind it.
// ----------------------------------------------------------------------------
module bicolor_led_blink_controller
    import blc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  blc_req_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output blc_rsp_t             rsp,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [PERIOD_W-1:0]  cfg_wdata
);

    logic     req_fire;
    logic     stage_valid;
    blc_req_t stage_item;
    logic     stage_fire;
    logic     out_can_load;
    blc_rsp_t result;

    assign stage_fire = stage_valid && out_can_load;
    assign req_ready  = !stage_valid || stage_fire;
    assign req_fire   = req_valid && req_ready;

    blc_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (req_fire),
        .load_data (req),
        .advance   (stage_fire),
        .valid     (stage_valid),
        .data      (stage_item)
    );

    blc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (stage_fire),
        .item      (stage_item),
        .result    (result)
    );

    blc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stage_fire),
        .load_data (result),
        .take      (rsp_ready),
        .can_load  (out_can_load),
        .valid     (rsp_valid),
        .data      (rsp)
    );

    a_req_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> stage_valid)
        else $error("accepted request not held in the request register");

    a_stage_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire |=> rsp_valid)
        else $error("consumed request produced no response");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !stage_fire)
        else $error("pending response overwritten");

endmodule
